### hdl/edfs_pkg.sv
// ----------------------------------------------------------------------------
// edfs_pkg: shared types and constants of the EDF tick scheduler
// Holds the stream field layout, the action codes and the command and
// status structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package edfs_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned RUN_W   = 5;
  localparam int unsigned CNT_W   = 5;

  // Input request: tdata = task_slot, arrival_time, burst_length, task_deadline.
  localparam int unsigned S_SLOT_LSB = 0;
  localparam int unsigned S_ARR_LSB  = S_SLOT_LSB + SLOT_W;
  localparam int unsigned S_BUR_LSB  = S_ARR_LSB + FIELD_W;
  localparam int unsigned S_DL_LSB   = S_BUR_LSB + FIELD_W;
  localparam int unsigned S_USED_W   = S_DL_LSB + FIELD_W;
  localparam int unsigned S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

  // Result request: tdata = running_task, tick_time, completion, turnaround, waiting.
  localparam int unsigned M_RUN_LSB  = 0;
  localparam int unsigned M_TIME_LSB = M_RUN_LSB + RUN_W;
  localparam int unsigned M_COMP_LSB = M_TIME_LSB + FIELD_W;
  localparam int unsigned M_TURN_LSB = M_COMP_LSB + FIELD_W;
  localparam int unsigned M_WAIT_LSB = M_TURN_LSB + FIELD_W;
  localparam int unsigned M_USED_W   = M_WAIT_LSB + FIELD_W;
  localparam int unsigned M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  // Saturation limit of the finished counter.
  localparam logic [CNT_W-1:0] FIN_MAX = '1;

  // Action codes carried in the input tuser.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write a task into its slot
    logic scan_start;  // clear the scan counter and the best candidate
    logic scan_rd;     // read the slot under the scan counter
    logic commit;      // apply the tick and load the result register
    logic done_res;    // load the all-done result
  } edfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic all_done;   // every configured task has finished
    logic scan_last;  // the scan counter sits on the last slot in use
    logic out_free;   // the result register can take a new result
  } edfs_sts_t;

endpackage

### hdl/edfs_ctrl.sv
// ----------------------------------------------------------------------------
// edfs_ctrl: sequencer of the EDF tick scheduler
// Accepts requests, walks the slot scan, the pick read and the commit, and
// holds a finished tick until the result register is free.
// ----------------------------------------------------------------------------
module edfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                s_axis_tuser,
  input  edfs_pkg::edfs_sts_t sts_i,
  output edfs_pkg::edfs_cmd_t cmd_o
);
  import edfs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_PICK   = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.all_done) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/edfs_dpath.sv
// ----------------------------------------------------------------------------
// edfs_dpath: task tables, scan compare and result register
// Keeps the per-slot task memories, searches them one slot a cycle for the
// earliest ready deadline, applies the tick and holds the result.
// ----------------------------------------------------------------------------
module edfs_dpath #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [edfs_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [edfs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [edfs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  edfs_pkg::edfs_cmd_t                cmd_i,
  output edfs_pkg::edfs_sts_t                sts_o
);
  import edfs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
  localparam int unsigned NC_W   = $clog2(MAX_TASKS + 1);
  localparam int unsigned N_W    = (NC_W > CNT_W) ? NC_W : CNT_W;
  localparam int unsigned WIDE_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  // Task tables.
  logic [TIME_BITS-1:0] arr_mem [MAX_TASKS];
  logic [FIELD_W-1:0]   bur_mem [MAX_TASKS];
  logic [FIELD_W-1:0]   dl_mem  [MAX_TASKS];
  logic [FIELD_W-1:0]   rem_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] rem_vld_q;

  logic [TIME_BITS-1:0] arr_rd_q;
  logic [FIELD_W-1:0]   bur_rd_q, dl_rd_q, rem_rd_q;

  logic [CNT_W-1:0]     task_count_q;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [CNT_W-1:0]     fin_q, fin_d;
  logic [N_W-1:0]       n_use;

  logic [IDX_W-1:0]     cnt_q, cmp_idx_q, pick_q, rd_addr;
  logic                 cmp_vld_q, found_q;
  logic [FIELD_W-1:0]   best_q;
  logic                 ready_hit;

  logic [SLOT_W-1:0]    ld_slot;
  logic [IDX_W-1:0]     ld_idx;
  logic                 ld_en;

  logic                 fin_now;
  logic [IDX_W:0]       pick_p1;
  logic [TIME_BITS-1:0] turn;
  logic [WIDE_W-1:0]    turn_w, bur_w, wait_w;

  logic                 out_vld_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                 out_user_q, out_last_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      task_count_q <= cfg_wdata_i;
    end
  end

  // Slots in use are capped by the table depth.
  assign n_use = (32'(task_count_q) < MAX_TASKS) ? N_W'(task_count_q) : N_W'(MAX_TASKS);

  // Load decode.
  assign ld_slot = s_axis_tdata[S_ARR_LSB-1:S_SLOT_LSB];
  assign ld_idx  = IDX_W'(ld_slot);
  assign ld_en   = cmd_i.load && (32'(ld_slot) < MAX_TASKS);

  // Table writes: a load writes every table, a commit writes the remaining work.
  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      arr_mem[ld_idx] <= TIME_BITS'(s_axis_tdata[S_BUR_LSB-1:S_ARR_LSB]);
      bur_mem[ld_idx] <= s_axis_tdata[S_DL_LSB-1:S_BUR_LSB];
      dl_mem[ld_idx]  <= s_axis_tdata[S_USED_W-1:S_DL_LSB];
      rem_mem[ld_idx] <= s_axis_tdata[S_DL_LSB-1:S_BUR_LSB];
    end else if (cmd_i.commit && found_q) begin
      rem_mem[pick_q] <= rem_rd_q - 1'b1;
    end
  end

  // Valid bits make never-written remaining work read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_vld_q <= '0;
    end else if (ld_en) begin
      rem_vld_q[ld_idx] <= 1'b1;
    end
  end

  // Registered table reads at the scan counter or at the picked slot.
  assign rd_addr = cmd_i.scan_rd ? cnt_q : pick_q;

  always_ff @(posedge clk_i) begin
    arr_rd_q <= arr_mem[rd_addr];
    bur_rd_q <= bur_mem[rd_addr];
    dl_rd_q  <= dl_mem[rd_addr];
    rem_rd_q <= rem_vld_q[rd_addr] ? rem_mem[rd_addr] : '0;
  end

  // Scan counter and compare pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      cmp_idx_q <= cnt_q;
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.scan_last = (N_W'(cnt_q) == (n_use - 1'b1));

  // Earliest ready deadline; strict less keeps the lowest slot on ties.
  assign ready_hit = (arr_rd_q <= time_q) && (rem_rd_q != '0) &&
                     (!found_q || (dl_rd_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
      pick_q  <= '0;
    end else if (cmd_i.scan_start) begin
      found_q <= 1'b0;
    end else if (cmp_vld_q && ready_hit) begin
      found_q <= 1'b1;
      best_q  <= dl_rd_q;
      pick_q  <= cmp_idx_q;
    end
  end

  // Tick arithmetic: saturating time, completion and waiting figures.
  assign time_d  = (time_q == '1) ? time_q : time_q + 1'b1;
  assign fin_now = found_q && (rem_rd_q == FIELD_W'(1));
  assign fin_d   = (fin_now && (fin_q != FIN_MAX)) ? fin_q + 1'b1 : fin_q;
  assign pick_p1 = {1'b0, pick_q} + 1'b1;
  assign turn    = time_d - arr_rd_q;
  assign turn_w  = WIDE_W'(turn);
  assign bur_w   = WIDE_W'(bur_rd_q);
  assign wait_w  = (turn_w >= bur_w) ? turn_w - bur_w : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      fin_q  <= '0;
    end else if (cmd_i.commit) begin
      time_q <= time_d;
      fin_q  <= fin_d;
    end
  end

  assign sts_o.all_done = (N_W'(fin_q) >= n_use);

  // Result register, refilled in the cycle the old result is taken.
  assign sts_o.out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.done_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Next result fields: a commit reports the tick, otherwise the all-done result.
  always_comb begin
    out_data_d = '0;
    if (cmd_i.commit) begin
      out_data_d[M_TIME_LSB-1:M_RUN_LSB]  = found_q ? RUN_W'(pick_p1) : '0;
      out_data_d[M_COMP_LSB-1:M_TIME_LSB] = FIELD_W'(time_d);
      if (fin_now) begin
        out_data_d[M_TURN_LSB-1:M_COMP_LSB] = FIELD_W'(time_d);
        out_data_d[M_WAIT_LSB-1:M_TURN_LSB] = FIELD_W'(turn);
        out_data_d[M_USED_W-1:M_WAIT_LSB]   = FIELD_W'(wait_w);
      end
    end else begin
      out_data_d[M_COMP_LSB-1:M_TIME_LSB] = FIELD_W'(time_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit || cmd_i.done_res) begin
      out_data_q <= out_data_d;
      out_user_q <= cmd_i.commit && fin_now;
      out_last_q <= cmd_i.done_res || (N_W'(fin_d) >= n_use);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/edf_tick_scheduler.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler: preemptive earliest-deadline-first tick scheduler
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries requests; tuser selects load (0) or tick (1).
//   A load writes arrival, burst and deadline into a slot and gives no
//   result. A tick scans the slots in use one a cycle through the
//   single read port of the task tables, picks the earliest ready deadline,
//   runs it one time unit and sends one result on the output stream.
//   The result tuser flags a task finished this tick; tlast is all_done.
//   No request is accepted while a tick runs; the next is taken once the
//   tick's result is loaded. A tick scans the n slots in use (task_count
//   capped by MAX_TASKS); one after every task has finished skips the scan.
//   task_count is written through cfg_we_i and cfg_wdata_i while idle; the
//   user keeps to this, as the block does not enforce it. Reset clears time,
//   the finished count, remaining work and task_count goes to 1. A stalled
//   result is held in the output register; loads are still taken meanwhile,
//   and the next tick waits at its commit or at its all-done result until
//   the result register frees.
// ----------------------------------------------------------------------------
module edf_tick_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: task_count.
  input  logic                           cfg_we_i,
  input  logic [edfs_pkg::CNT_W-1:0]     cfg_wdata_i,
  // Input requests.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata from bit 0: task_slot, arrival_time, burst_length, task_deadline.
  input  logic [edfs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: action.
  input  logic                           s_axis_tuser,
  // Results.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0: running_task, tick_time, completion_time,
  // turnaround_time, waiting_time.
  output logic [edfs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // tuser: task_finished.
  output logic                           m_axis_tuser,
  // tlast: all_done.
  output logic                           m_axis_tlast
);
  import edfs_pkg::*;

  edfs_cmd_t cmd;
  edfs_sts_t sts;

  edfs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  edfs_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### hdl/edfs_checker.sv
// ----------------------------------------------------------------------------
// edfs_checker: port-level checks of the EDF tick scheduler
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module edfs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [edfs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import edfs_pkg::*;

  logic [RUN_W-1:0]   run_f;
  logic [FIELD_W-1:0] time_f, comp_f;

  assign run_f  = m_axis_tdata[M_TIME_LSB-1:M_RUN_LSB];
  assign time_f = m_axis_tdata[M_COMP_LSB-1:M_TIME_LSB];
  assign comp_f = m_axis_tdata[M_TURN_LSB-1:M_COMP_LSB];

  // A stalled result holds its content.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A tick keeps the block busy: no request is accepted right after it.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_TICK) |=> !s_axis_tready)
    else $error("request accepted right after a tick");

  // A finish names a task and completes at the reported time.
  a_fin_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (run_f != '0) && (comp_f == time_f))
    else $error("finished result with bad task or completion time");

  // all_done with a running task means that task just finished.
  a_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && (run_f != '0) |-> m_axis_tuser)
    else $error("all_done raised without the running task finishing");

endmodule

bind edf_tick_scheduler edfs_checker u_edfs_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench of the EDF tick scheduler
// Loads tasks and issues ticks through the input stream and checks every
// tick result against a cycle-free EDF predictor kept in the testbench.
// After a short directed opening, random load/tick batches run under several
// task counts, and a final random part lets tasks finish freely, its first
// stretch with both sides always ready.
// ----------------------------------------------------------------------------
module tb_top;
  import edfs_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam logic [15:0] TMAX       = 16'hFFFF;
  // Settling margin: room for the longest tick and a held result.
  localparam int unsigned SETTLE     = 2 * SLOTS + 8;
  // Completions allowed in the random phases; later tasks are kept busy.
  localparam int unsigned PRE_BUDGET = 4;
  localparam int unsigned BATCH      = 12;
  localparam longint unsigned LIMIT  = 4_000_000;

  typedef struct packed {
    logic        action;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] deadline;
  } task_req_t;

  typedef struct packed {
    logic [4:0]  run_slot;
    logic [15:0] now_time;
    logic        finished;
    logic [15:0] comp_time;
    logic [15:0] turn_time;
    logic [15:0] wait_time;
    logic        all_done;
  } tick_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // While set, neither side idles.
  logic quiet = 1'b0;

  // Scheduler state as the testbench predicts it.
  logic [15:0] arr_tab [SLOTS] = '{default: '0};
  logic [15:0] bur_tab [SLOTS] = '{default: '0};
  logic [15:0] dl_tab  [SLOTS] = '{default: '0};
  logic [15:0] rem_tab [SLOTS] = '{default: '0};
  logic [15:0] sched_now = '0;
  logic [4:0]  fin_cnt   = '0;
  logic [4:0]  slot_cfg  = 5'd1;

  task_req_t       pending_reqs[$];
  tick_result_t    expected_ticks[$];
  task_req_t       in_flight = '0;
  int unsigned     errors = 0;
  int unsigned     results_seen = 0;
  longint unsigned cycles = 0;

  edf_tick_scheduler #(
    .MAX_TASKS(SLOTS),
    .TIME_BITS(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned slots_used();
    return (slot_cfg < SLOTS) ? slot_cfg : SLOTS;
  endfunction

  // EDF step for one accepted request; a tick queues its expected result.
  task automatic predict_edf(input task_req_t r);
    int unsigned  n;
    int unsigned  i;
    int unsigned  pick;
    logic         found;
    logic [15:0]  best;
    tick_result_t res;
    n     = slots_used();
    found = 1'b0;
    pick  = 0;
    best  = '0;
    res   = '0;
    if (r.action == ACT_LOAD) begin
      arr_tab[r.slot] = r.arrival;
      bur_tab[r.slot] = r.burst;
      dl_tab[r.slot]  = r.deadline;
      rem_tab[r.slot] = r.burst;
    end else if (fin_cnt >= n) begin
      // Everything finished: time holds and only all_done is reported.
      res.now_time = sched_now;
      res.all_done = 1'b1;
      expected_ticks.push_back(res);
    end else begin
      for (i = 0; i < n; i++) begin
        if (rem_tab[i] != 0 && arr_tab[i] <= sched_now && (!found || dl_tab[i] < best)) begin
          found = 1'b1;
          best  = dl_tab[i];
          pick  = i;
        end
      end
      if (sched_now != TMAX) sched_now++;
      if (found) begin
        res.run_slot = 5'(pick + 1);
        rem_tab[pick]--;
        if (rem_tab[pick] == 0) begin
          if (fin_cnt != 5'h1F) fin_cnt++;
          res.finished  = 1'b1;
          res.comp_time = sched_now;
          res.turn_time = sched_now - arr_tab[pick];
          // Saturated time can leave the turnaround below the burst.
          res.wait_time = (res.turn_time >= bur_tab[pick]) ?
                          res.turn_time - bur_tab[pick] : '0;
        end
      end
      res.now_time = sched_now;
      res.all_done = (fin_cnt >= n);
      expected_ticks.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Request driver: holds each request until accepted, idles at random.
  always @(posedge clk_i) begin : drive_requests
    task_req_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_edf(in_flight);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
        nxt = pending_reqs.pop_front();
        in_flight     <= nxt;
        s_axis_tdata  <= S_TDATA_W'({nxt.deadline, nxt.burst, nxt.arrival, nxt.slot});
        s_axis_tuser  <= nxt.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    tick_result_t got;
    tick_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.run_slot  = m_axis_tdata[M_RUN_LSB +: RUN_W];
      got.now_time  = m_axis_tdata[M_TIME_LSB +: FIELD_W];
      got.comp_time = m_axis_tdata[M_COMP_LSB +: FIELD_W];
      got.turn_time = m_axis_tdata[M_TURN_LSB +: FIELD_W];
      got.wait_time = m_axis_tdata[M_WAIT_LSB +: FIELD_W];
      got.finished  = m_axis_tuser;
      got.all_done  = m_axis_tlast;
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("result with none expected (task %0d, time %0d)",
                                  got.run_slot, got.now_time));
      end else begin
        want = expected_ticks.pop_front();
        check_field("running_task", 16'(got.run_slot), 16'(want.run_slot));
        check_field("tick_time", got.now_time, want.now_time);
        check_field("task_finished", 16'(got.finished), 16'(want.finished));
        check_field("completion_time", got.comp_time, want.comp_time);
        check_field("turnaround_time", got.turn_time, want.turn_time);
        check_field("waiting_time", got.wait_time, want.wait_time);
        check_field("all_done", 16'(got.all_done), 16'(want.all_done));
      end
      results_seen++;
    end
    m_axis_tready <= rst_ni && (quiet || $urandom_range(99) >= 25);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic push_load(input logic [3:0] slot, input logic [15:0] arr,
                           input logic [15:0] bur, input logic [15:0] dl);
    task_req_t r;
    r.action   = ACT_LOAD;
    r.slot     = slot;
    r.arrival  = arr;
    r.burst    = bur;
    r.deadline = dl;
    pending_reqs.push_back(r);
  endtask

  // A tick carries random, ignored data fields.
  task automatic push_tick();
    task_req_t r;
    r.action   = ACT_TICK;
    r.slot     = 4'($urandom);
    r.arrival  = 16'($urandom);
    r.burst    = 16'($urandom);
    r.deadline = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_accepted();
    do @(negedge clk_i); while (pending_reqs.size() != 0 || s_axis_tvalid);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_ticks.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    slot_cfg     = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly ready arrivals, some just ahead of time, a few at the extremes.
  function automatic logic [15:0] pick_arrival();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return TMAX;
    if (r < 15) return 16'($urandom);
    if (r < 65) return 16'($urandom_range(sched_now));
    return (sched_now > TMAX - 20) ? TMAX : sched_now + 16'($urandom_range(1, 20));
  endfunction

  // With hold_work set, bursts are long enough that no task finishes.
  function automatic logic [15:0] pick_burst(input bit hold_work);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return TMAX;
    if (r < 12) return 16'($urandom_range(hold_work ? 300 : 1, 65535));
    if (hold_work) return 16'($urandom_range(300, 4000));
    if (r < 45) return 16'($urandom_range(1, 4));
    return 16'($urandom_range(5, 200));
  endfunction

  // Deadlines from a narrow range give frequent ties.
  function automatic logic [15:0] pick_deadline();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return TMAX;
    if (r < 70) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  // One batch of random loads and ticks. In the random phases the
  // number of completions is rationed: once the budget is spent, nearly
  // finished tasks are refilled so that no further task completes.
  task automatic random_batch(input bit allow_finish);
    int unsigned s;
    bit          hold;
    wait_accepted();
    hold = !allow_finish && fin_cnt >= PRE_BUDGET;
    if (hold) begin
      for (s = 0; s < SLOTS; s++) begin
        if (rem_tab[s] != 0 && rem_tab[s] < 16) begin
          push_load(4'(s), arr_tab[s], pick_burst(1'b1), dl_tab[s]);
        end
      end
    end
    repeat (BATCH) begin
      if ($urandom_range(99) < 45) begin
        push_load(4'($urandom), pick_arrival(), pick_burst(hold), pick_deadline());
      end else begin
        push_tick();
      end
    end
  endtask

  initial begin
    int unsigned ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing loaded yet: the tick runs idle.
    push_tick();
    // A task count of zero reports all_done on the first tick.
    wait_idle();
    write_count(5'd0);
    push_tick();

    // Count above the slot limit; extremes, a tie, a preemption, a reload.
    wait_idle();
    write_count(5'd31);
    push_load(4'd0, 16'd0, 16'd1, TMAX);
    push_load(4'd15, TMAX, TMAX, 16'd0);
    push_load(4'd3, 16'd2, 16'd2, 16'd5);
    push_load(4'd4, 16'd2, 16'd50, 16'd5);
    repeat (3) push_tick();
    push_load(4'd5, 16'd5, 16'd100, 16'd2);
    repeat (3) push_tick();
    push_load(4'd4, 16'd0, 16'd3, 16'd1);
    repeat (2) push_tick();

    // Random phases under several task counts, one of them already done.
    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_count(5'd16);
        end
        1: begin
          write_count(5'($urandom_range(fin_cnt + 1, SLOTS)));
        end
        2: begin
          write_count(5'($urandom_range(fin_cnt, 0)));
        end
        3: begin
          write_count(5'd31);
        end
        default: begin
          write_count(5'($urandom_range(fin_cnt + 1, SLOTS)));
        end
      endcase
      repeat ((ph == 2) ? 3 : 34) random_batch(1'b0);
    end

    // Random requests with completions allowed; the first stretch runs
    // with both sides always ready.
    wait_idle();
    write_count(5'd16);
    quiet <= 1'b1;
    repeat (12) random_batch(1'b1);
    wait_accepted();
    quiet <= 1'b0;
    repeat (13) random_batch(1'b1);

    wait_idle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### edf_tick_scheduler.f
hdl/edfs_pkg.sv
hdl/edfs_ctrl.sv
hdl/edfs_dpath.sv
hdl/edf_tick_scheduler.sv
hdl/edfs_checker.sv
test/tb_top.sv
